@@ rtl/core/mts_pkg.sv @@
`default_nettype none

package mts_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 256;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Fixed field widths on the stream ports.
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Word returned for a pop or query on an empty stack.
    localparam logic [DATA_WIDTH-1:0] WORD_ONES = {DATA_WIDTH{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // carry out the captured request and load the result
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // the result register can take a new result this cycle
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/core/mts_ram.sv @@
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/core/mts_ctrl.sv @@
`default_nettype none

module mts_ctrl
    import mts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_dp_status i_status,
    output logic            o_in_ready,
    output t_ctrl_cmd       o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   accept;
    logic   exec;

    assign accept = i_in_valid && r_in_ready;
    assign exec   = (r_state == S_EXEC) && i_status.out_free;

    // The request waits in EXEC after its accept in IDLE so that the stack top read
    // settles in the memories before the request is carried out.
    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state    = S_EXEC;
                    n_in_ready = 1'b0;
                end
            end
            S_EXEC: begin
                if (exec) begin
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd.load = accept;
    assign o_cmd.exec = exec;

endmodule

`default_nettype wire

@@ rtl/core/mts_datapath.sv @@
`default_nettype none

module mts_datapath
    import mts_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_ctrl_cmd           i_cmd,
    input  wire logic [REQ_W-1:0]    i_req_type,
    input  wire logic [FIELD_W-1:0]  i_push_value,
    input  wire logic                i_out_ready,
    output t_dp_status               o_status,
    output logic                     o_out_valid,
    output logic [FIELD_W-1:0]       o_result_value,
    output logic [STATUS_W-1:0]      o_result_status
);

    logic [REQ_W-1:0]      r_req;
    logic [DATA_WIDTH-1:0] r_word;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0] r_res, n_res;
    logic [STATUS_W-1:0]   r_st, n_st;

    logic                  stack_empty;
    logic                  stack_full;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] new_min;
    logic [DATA_WIDTH-1:0] top_value;
    logic [DATA_WIDTH-1:0] top_min;

    assign stack_empty = (r_count == '0);
    assign stack_full  = (r_count == CNT_W'(STACK_DEPTH));

    // Both memories are always read at the current top; the address only
    // moves when the count does, and the read data follows in the next cycle.
    assign rd_addr = ADDR_W'(r_count - CNT_W'(1));
    assign wr_addr = ADDR_W'(r_count);

    mts_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_word),
        .i_rd_addr (rd_addr),
        .o_rd_data (top_value)
    );

    mts_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_min_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (new_min),
        .i_rd_addr (rd_addr),
        .o_rd_data (top_min)
    );

    // The running minimum is the new word on an empty stack, otherwise the
    // smaller of the word and the minimum below it.
    assign new_min = (!stack_empty && ($signed(top_min) < $signed(r_word))) ? top_min : r_word;

    always_comb begin
        n_count     = r_count;
        n_res       = r_res;
        n_st        = r_st;
        wr_en       = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.exec) begin
            n_out_valid = 1'b1;
            n_res       = '0;
            n_st        = ST_OK;
            case (r_req)
                REQ_PUSH: begin
                    if (stack_full) begin
                        n_st = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                REQ_POP: begin
                    if (stack_empty) begin
                        n_res = WORD_ONES;
                        n_st  = ST_EMPTY;
                    end else begin
                        n_res   = top_value;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                REQ_QUERY: begin
                    if (stack_empty) begin
                        n_res = WORD_ONES;
                        n_st  = ST_EMPTY;
                    end else begin
                        n_res = top_min;
                    end
                end
                default: begin
                    // Unused code: no state change, zero result, ok status.
                    n_res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_word <= DATA_WIDTH'(i_push_value);
        end
        r_res <= n_res;
        r_st  <= n_st;
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_result_value    = FIELD_W'(r_res);
    assign o_result_status   = r_st;

endmodule

`default_nettype wire

@@ rtl/core/min_tracking_stack_core.sv @@
// Channel   Dir  Handshake                    tdata                tuser
// s_axis    in   s_axis_tvalid/s_axis_tready  [31:0] push_value    [1:0] req_type
// m_axis    out  m_axis_tvalid/m_axis_tready  [31:0] result_value  [1:0] status
//
// Every request is first accepted while both stack memories present their
// top entries, and then carried out with its result loaded.
// The registered read of each stack memory calls for that split into accept and execute.
// A request is accepted while the previous result still waits in the output
// register; it then holds in execution until that result is taken.
// Reset (i_rst_n, synchronous, active low) empties the stack and the output.
`default_nettype none

module min_tracking_stack_core
    import mts_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Request items.
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [FIELD_W-1:0]  s_axis_tdata,   // [31:0] push_value
    input  wire logic [REQ_W-1:0]    s_axis_tuser,   // [1:0] req_type
    // Result items.
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [FIELD_W-1:0]       m_axis_tdata,   // [31:0] result_value
    output logic [STATUS_W-1:0]      m_axis_tuser    // [1:0] status
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // The controller sequences each request through accept and execute.
    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // The datapath holds the entry count, the value and minimum stacks and
    // the result register that drives the output channel.
    mts_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (s_axis_tuser),
        .i_push_value    (s_axis_tdata),
        .i_out_ready     (m_axis_tready),
        .o_status        (status),
        .o_out_valid     (m_axis_tvalid),
        .o_result_value  (m_axis_tdata),
        .o_result_status (m_axis_tuser)
    );

    // Only one request is in flight: ready drops right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // With the output free at accept, the request runs through EXEC unstalled and its result follows.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready))
        |=> ##1 m_axis_tvalid)
        else $error("result missing after request");

    // An empty stack answers with all ones.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)) |-> (m_axis_tdata == FIELD_W'(WORD_ONES)))
        else $error("empty status without all-ones result");

    // A dropped push answers with zero.
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (m_axis_tdata == '0))
        else $error("full status with nonzero result");

endmodule

`default_nettype wire

@@ verif/min_tracking_stack_core_tb.sv @@
`default_nettype none

module min_tracking_stack_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    // Request code that the block takes and answers with a plain zero result.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Stimulus size and run guard. The guard allows for every item waiting out
    // the longest sender gap, the accept and execute steps of the block and the
    // longest receiver stall, several times over.
    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int CYCLE_LIMIT    = 400000;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} t_phase_kind;

    // Keeps its own copy of both stacks, works out the result of every
    // accepted request and holds those results until the block returns them.
    class min_stack_scoreboard;
        typedef struct packed {
            logic [FIELD_W-1:0]  value;
            logic [STATUS_W-1:0] status;
        } t_stack_result;

        logic [DATA_WIDTH-1:0] word_stack[STACK_DEPTH];
        logic [DATA_WIDTH-1:0] min_stack[STACK_DEPTH];
        int unsigned           held;
        t_stack_result         awaited_results[$];
        int                    errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [FIELD_W-1:0] data);
            t_stack_result         r;
            logic [DATA_WIDTH-1:0] word;
            logic [DATA_WIDTH-1:0] running_min;
            r.value  = '0;
            r.status = ST_OK;
            word     = data[DATA_WIDTH-1:0];
            case (req)
                REQ_PUSH: begin
                    if (held >= STACK_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        running_min = word;
                        if (held > 0 && $signed(min_stack[held-1]) < $signed(word))
                            running_min = min_stack[held-1];
                        word_stack[held] = word;
                        min_stack[held]  = running_min;
                        held++;
                    end
                end
                REQ_POP: begin
                    if (held == 0) begin
                        r.value[DATA_WIDTH-1:0] = WORD_ONES;
                        r.status = ST_EMPTY;
                    end else begin
                        held--;
                        r.value[DATA_WIDTH-1:0] = word_stack[held];
                    end
                end
                REQ_QUERY: begin
                    if (held == 0) begin
                        r.value[DATA_WIDTH-1:0] = WORD_ONES;
                        r.status = ST_EMPTY;
                    end else begin
                        r.value[DATA_WIDTH-1:0] = min_stack[held-1];
                    end
                end
                default: ;
            endcase
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [FIELD_W-1:0] value, logic [STATUS_W-1:0] status);
            t_stack_result want;
            if (awaited_results.size() == 0) begin
                $display("%0t: result with nothing awaited, value %h status %0d",
                         $time, value, status);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (value !== want.value) begin
                $display("%0t: result_value mismatch, expected %h actual %h",
                         $time, want.value, value);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, status);
                errors++;
            end
        endfunction
    endclass

    // All block inputs start at known values.
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [FIELD_W-1:0]  s_axis_tdata  = '0;   // [31:0] push_value
    logic [REQ_W-1:0]    s_axis_tuser  = '0;   // [1:0] req_type
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [FIELD_W-1:0]  m_axis_tdata;         // [31:0] result_value
    logic [STATUS_W-1:0] m_axis_tuser;         // [1:0] status

    min_stack_scoreboard sb;

    // When set, neither side inserts gaps, so the block sees back-to-back items.
    bit          no_idle = 1'b0;
    int          items_sent = 0;
    int unsigned stim_depth = 0;   // stack depth as the stimulus expects it
    int          sink_draw;
    int          sink_wait = 0;
    int          cycle_count = 0;

    min_tracking_stack_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Both handshakes are observed in one process, so the order of checking
    // and predicting is fixed. A result taken together with an accept always
    // belongs to an earlier request, so it is checked first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata);
        end
    end

    // Receiver: after each taken result, draw how many cycles to hold ready low.
    // The stall runs whether or not a result is waiting; of the block's work
    // only the execute step waits on it, since accept does not look at ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_wait     <= 0;
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            sink_draw      = no_idle ? 0 : $urandom_range(0, 9);
            sink_wait     <= sink_draw;
            m_axis_tready <= (sink_draw == 0);
        end else if (sink_wait > 0) begin
            sink_wait     <= sink_wait - 1;
            m_axis_tready <= (sink_wait == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Presents one request after a random gap and returns at the edge where it
    // is accepted. With no gap, valid simply stays high for the next item.
    task automatic issue(input logic [REQ_W-1:0] req, input logic [FIELD_W-1:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (req == REQ_PUSH && stim_depth < STACK_DEPTH)
            stim_depth++;
        else if (req == REQ_POP && stim_depth > 0)
            stim_depth--;
    endtask

    // Holds the sender off until every awaited result has come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // Words to push: mostly full random, with a share of the signed extremes
    // and of small values near zero, which makes equal minimums common.
    function automatic logic [FIELD_W-1:0] draw_word();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return FIELD_W'($urandom_range(0, 16)) - FIELD_W'(8);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_phase_kind        kind;
        int                 phase;
        int                 n;
        int                 pick;
        bit                 falling;
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] word;

        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty-stack answers, the unused code, the signed
        // extremes, a tie on the minimum, and unwinding the minimum by pops.
        issue(REQ_POP,    $urandom);
        issue(REQ_QUERY,  $urandom);
        issue(REQ_UNUSED, $urandom);
        issue(REQ_PUSH,   32'h7FFF_FFFF);
        issue(REQ_QUERY,  $urandom);
        issue(REQ_PUSH,   32'h8000_0000);
        issue(REQ_QUERY,  $urandom);
        issue(REQ_PUSH,   32'h0000_0000);
        issue(REQ_QUERY,  $urandom);
        issue(REQ_PUSH,   32'hFFFF_FFFF);
        issue(REQ_PUSH,   32'h8000_0000);
        issue(REQ_QUERY,  $urandom);
        issue(REQ_UNUSED, 32'hFFFF_FFFF);
        issue(REQ_POP,    $urandom);
        issue(REQ_QUERY,  $urandom);
        issue(REQ_POP,    $urandom);
        issue(REQ_POP,    $urandom);
        issue(REQ_QUERY,  $urandom);
        issue(REQ_POP,    $urandom);
        issue(REQ_QUERY,  $urandom);
        issue(REQ_POP,    $urandom);
        issue(REQ_POP,    $urandom);
        issue(REQ_PUSH,   32'h0000_0001);
        issue(REQ_POP,    $urandom);

        // Random part in phases. The first phase fills the stack past full,
        // the second empties it again after a full drain of results; later
        // phases are drawn at random, mostly mixed traffic.
        phase = 0;
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 0) begin
                kind = PH_FILL;
            end else if (phase == 1) begin
                kind = PH_DRAIN;
            end else begin
                pick = $urandom_range(0, 5);
                kind = (pick == 0) ? PH_FILL : (pick == 1) ? PH_DRAIN : PH_MIX;
            end
            if (phase == 1 || $urandom_range(0, 7) == 0)
                settle();

            case (kind)
                PH_FILL: begin
                    // A falling run pushes a base word that steps down by zero to three after each push.
                    falling = $urandom_range(0, 1);
                    base    = $urandom;
                    while (stim_depth < STACK_DEPTH) begin
                        if ($urandom_range(0, 9) == 0) begin
                            issue(REQ_QUERY, $urandom);
                        end else begin
                            word = falling ? base : draw_word();
                            base = base - FIELD_W'($urandom_range(0, 3));
                            issue(REQ_PUSH, word);
                        end
                    end
                    // Pushes on a full stack are dropped.
                    repeat ($urandom_range(1, 3)) issue(REQ_PUSH, draw_word());
                    issue(REQ_QUERY, $urandom);
                end
                PH_DRAIN: begin
                    while (stim_depth > 0) begin
                        if ($urandom_range(0, 9) == 0)
                            issue(REQ_QUERY, $urandom);
                        else
                            issue(REQ_POP, $urandom);
                    end
                    issue(REQ_POP, $urandom);
                    issue(REQ_QUERY, $urandom);
                end
                default: begin
                    n = $urandom_range(20, 80);
                    repeat (n) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 45)
                            issue(REQ_PUSH, draw_word());
                        else if (pick < 75)
                            issue(REQ_POP, $urandom);
                        else if (pick < 95)
                            issue(REQ_QUERY, $urandom);
                        else
                            issue(REQ_UNUSED, $urandom);
                    end
                end
            endcase
            phase++;
        end

        // Wait for the last results, then a few cycles more so that any
        // spurious extra result would still be caught.
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
